// ===== hw/rtl/cmrt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmrt_pkg: shared types and constants of the message reliability tracker.
// Holds opcodes, message types, kinds, result codes and the sequencer states.
// ----------------------------------------------------------------------------
package cmrt_pkg;

    localparam int unsigned TABLE_DEPTH_DEF = 8;

    localparam logic [15:0] BASE_TIMEOUT_RST = 16'd2000;
    localparam logic [15:0] JITTER_SPAN_RST  = 16'd1000;
    localparam logic [2:0]  MAX_RETRIES_RST  = 3'd4;

    localparam logic [1:0] CFG_BASE    = 2'd0;
    localparam logic [1:0] CFG_JITTER  = 2'd1;
    localparam logic [1:0] CFG_RETRIES = 2'd2;

    localparam logic [1:0] OP_TRANSMIT = 2'd0;
    localparam logic [1:0] OP_RECEIVE  = 2'd1;
    localparam logic [1:0] OP_TICK     = 2'd2;
    localparam logic [1:0] OP_UNUSED   = 2'd3;

    localparam logic [1:0] TYPE_CON = 2'd0;
    localparam logic [1:0] TYPE_RST = 2'd3;

    localparam logic [1:0] KIND_REQUEST  = 2'd0;
    localparam logic [1:0] KIND_RESPONSE = 2'd1;
    localparam logic [1:0] KIND_EMPTY    = 2'd2;

    localparam logic [2:0] ACT_SEND_NEW = 3'd0;
    localparam logic [2:0] ACT_RESEND   = 3'd1;
    localparam logic [2:0] ACT_SEND_RST = 3'd2;
    localparam logic [2:0] ACT_DELIVER  = 3'd3;
    localparam logic [2:0] ACT_COMPLETE = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_SPACE  = 2'd1;
    localparam logic [1:0] ST_CANCELLED = 2'd2;
    localparam logic [1:0] ST_TIMED_OUT = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_JITTER,
        S_STORE,
        S_SCAN,
        S_MATCHED,
        S_TICK_UPD,
        S_TICK_OUT,
        S_MOVE
    } t_state;

    // Bundle of one table entry.
    typedef struct packed {
        logic [47:0] peer;
        logic [15:0] id;
        logic [63:0] token;
        logic [3:0]  token_size;
        logic [1:0]  kind;
        logic        retrying;
        logic [2:0]  retry_count;
        logic [31:0] timeout;
        logic [31:0] deadline;
        logic [15:0] handle;
    } t_entry;

    // Control towards the remainder unit.
    typedef struct packed {
        logic        start;
        logic [15:0] dividend;
        logic [15:0] divisor;
    } t_rem_req;

    typedef struct packed {
        logic        done;
        logic [15:0] remainder;
    } t_rem_rsp;

    function automatic logic [1:0] kind_of(input logic [7:0] code);
        if (code[7:5] != 3'd0) begin
            return KIND_RESPONSE;
        end
        return (code != 8'd0) ? KIND_REQUEST : KIND_EMPTY;
    endfunction

endpackage

// ===== hw/rtl/cmrt_rem_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmrt_rem_unit: bit-serial remainder.
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cmrt_rem_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cmrt_pkg::t_rem_req i_req,
    output cmrt_pkg::t_rem_rsp o_rsp
);
    import cmrt_pkg::*;

    logic [15:0] r_rem, n_rem;
    logic [15:0] r_quo, n_quo;
    logic [15:0] r_div, n_div;
    logic [4:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [16:0] trial;

    // One shift-and-subtract step per cycle.
    always_comb begin
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_div  = r_div;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        trial  = {r_rem, r_quo[15]} - {1'b0, r_div};
        if (i_req.start) begin
            n_rem  = 16'd0;
            n_quo  = i_req.dividend;
            n_div  = i_req.divisor;
            n_cnt  = 5'd0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (trial[16]) begin
                n_rem = {r_rem[14:0], r_quo[15]};
            end else begin
                n_rem = trial[15:0];
            end
            n_quo = {r_quo[14:0], 1'b0};
            n_cnt = r_cnt + 5'd1;
            if (r_cnt == 5'd15) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 5'd0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_div <= n_div;
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.remainder = r_rem;

endmodule

// ===== hw/rtl/coap_message_reliability_tracker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coap_message_reliability_tracker: outstanding CoAP message table.
// Busy states per item: none for a full-table transmit or a received request;
// S_STORE for other transmits, and S_JITTER then S_STORE for a CON transmit
// with jitter, waiting in S_STORE for the bit-serial remainder unit; receive
// scans one entry a cycle until a hit, tick scans every stored entry.
// Synchronous active-low reset empties the table and loads register defaults.
// The result strobe lasts one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
module coap_message_reliability_tracker #(
    parameter int unsigned TABLE_DEPTH = cmrt_pkg::TABLE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic [1:0]  i_opcode,
    input  logic [31:0] i_now_ms,
    input  logic [47:0] i_peer_key,
    input  logic [1:0]  i_msg_type,
    input  logic [7:0]  i_msg_code,
    input  logic [15:0] i_message_id,
    input  logic [3:0]  i_token_size,
    input  logic [63:0] i_token_bytes,
    input  logic [15:0] i_msg_handle,
    input  logic [15:0] i_random_word,
    output logic        o_valid,
    output logic [2:0]  o_action,
    output logic [1:0]  o_status,
    output logic [15:0] o_entry_handle,
    output logic [15:0] o_incoming_handle,
    output logic [47:0] o_dest_peer,
    output logic [15:0] o_reset_id
);
    import cmrt_pkg::*;

    localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
    localparam int unsigned SW = ((IW > CW) ? IW : CW) + 1;
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    // Configuration registers.
    logic [15:0] r_base, r_jitter;
    logic [2:0]  r_max_retries;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base        <= BASE_TIMEOUT_RST;
            r_jitter      <= JITTER_SPAN_RST;
            r_max_retries <= MAX_RETRIES_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_BASE:    r_base        <= i_cfg_data;
                CFG_JITTER:  r_jitter      <= i_cfg_data;
                CFG_RETRIES: r_max_retries <= i_cfg_data[2:0];
                default:     ;
            endcase
        end
    end

    // Entry table, in flip-flops; the scan reads one entry per cycle by index.
    t_entry r_table [TABLE_DEPTH];

    t_state r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [IW-1:0] r_idx, n_idx;
    logic [IW-1:0] r_best, n_best;
    logic          r_found, n_found;
    logic [IW-1:0] r_dst, n_dst;

    // Latched input item.
    logic [1:0]  r_op, r_type;
    logic [1:0]  r_kind;
    logic [31:0] r_now;
    logic [47:0] r_peer;
    logic [15:0] r_id, r_handle, r_rnd;
    logic [3:0]  r_tlen;
    logic [63:0] r_tok;

    // Working entry and result registers.
    t_entry r_work, n_work;
    logic        r_valid, n_valid;
    logic [2:0]  r_act, n_act;
    logic [1:0]  r_stat, n_stat;
    logic [15:0] r_eh, n_eh, r_ih, n_ih, r_rid, n_rid;
    logic [47:0] r_dp, n_dp;

    logic          wr_en;
    logic [IW-1:0] wr_idx;
    t_entry        wr_data;

    t_rem_req rem_req;
    t_rem_rsp rem_rsp;

    cmrt_rem_unit u_rem (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (rem_req),
        .o_rsp  (rem_rsp)
    );

    // Token normalisation at accept time.
    logic [3:0]  in_tlen;
    logic [63:0] in_tok;
    always_comb begin
        in_tlen = (i_token_size > 4'd8) ? 4'd8 : i_token_size;
        for (int b = 0; b < 8; b++) begin
            in_tok[b*8 +: 8] = (b < int'(in_tlen)) ? i_token_bytes[b*8 +: 8] : 8'd0;
        end
    end

    logic   accept;
    t_entry cur;
    logic   hit, last_scan;
    assign accept    = start && (r_state == S_IDLE);
    assign cur       = r_table[r_idx];
    assign hit       = (cur.peer == r_peer) &&
                       ((cur.id == r_id) ||
                        ((cur.token_size == r_tlen) && (cur.token == r_tok)));
    assign last_scan = (SW'(r_idx) + SW'(1)) >= SW'(r_count);

    // Sequencer.
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_idx   = r_idx;
        n_best  = r_best;
        n_found = r_found;
        n_dst   = r_dst;
        n_work  = r_work;
        n_valid = 1'b0;
        n_act   = r_act;
        n_stat  = r_stat;
        n_eh    = r_eh;
        n_ih    = r_ih;
        n_rid   = r_rid;
        n_dp    = r_dp;
        wr_en   = 1'b0;
        wr_idx  = r_dst;
        wr_data = r_work;
        rem_req.start    = 1'b0;
        rem_req.dividend = r_rnd;
        rem_req.divisor  = r_jitter;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_idx   = '0;
                    n_found = 1'b0;
                    n_eh = '0; n_ih = '0; n_dp = '0; n_rid = '0;
                    n_stat = ST_OK;
                    case (i_opcode)
                        OP_TRANSMIT: begin
                            if (r_count >= DEPTH_C) begin
                                n_valid = 1'b1;
                                n_act   = ACT_COMPLETE;
                                n_stat  = ST_NO_SPACE;
                                n_eh    = i_msg_handle;
                            end else if (i_msg_type == TYPE_CON && i_random_word != 16'd0
                                         && r_jitter != 16'd0) begin
                                n_state = S_JITTER;
                            end else begin
                                n_state = S_STORE;
                            end
                        end
                        OP_RECEIVE: begin
                            if (kind_of(i_msg_code) == KIND_REQUEST) begin
                                n_valid = 1'b1;
                                n_act   = ACT_DELIVER;
                                n_ih    = i_msg_handle;
                                n_dp    = i_peer_key;
                            end else if (r_count != '0) begin
                                n_state = S_SCAN;
                            end else begin
                                n_state = S_MATCHED;
                            end
                        end
                        OP_TICK: begin
                            if (r_count != '0) begin
                                n_state = S_SCAN;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_JITTER: begin
                rem_req.start = 1'b1;
                n_state = S_STORE;
            end
            S_STORE: begin
                if (!(r_type == TYPE_CON && r_rnd != 16'd0 && r_jitter != 16'd0)
                    || rem_rsp.done) begin
                    n_state = S_IDLE;
                    n_valid = 1'b1;
                    n_act   = ACT_SEND_NEW;
                    n_eh    = r_handle;
                    n_dp    = r_peer;
                    if (r_type == TYPE_CON || r_kind == KIND_REQUEST) begin
                        wr_en   = 1'b1;
                        wr_idx  = r_count[IW-1:0];
                        wr_data.peer        = r_peer;
                        wr_data.id          = r_id;
                        wr_data.token       = r_tok;
                        wr_data.token_size  = r_tlen;
                        wr_data.kind        = r_kind;
                        wr_data.retrying    = (r_type == TYPE_CON);
                        wr_data.retry_count = 3'd0;
                        wr_data.handle      = r_handle;
                        if (r_type == TYPE_CON) begin
                            wr_data.timeout = {16'd0, r_base} +
                                ((r_rnd != 16'd0 && r_jitter != 16'd0) ?
                                 {16'd0, rem_rsp.remainder} : 32'd0);
                            wr_data.deadline = r_now + wr_data.timeout;
                        end else begin
                            wr_data.timeout  = 32'd0;
                            wr_data.deadline = 32'd0;
                        end
                        n_count = r_count + CW'(1);
                    end
                end
            end
            S_SCAN: begin
                n_idx = r_idx + IW'(1);
                if (r_op == OP_RECEIVE) begin
                    if (hit) begin
                        n_found = 1'b1;
                        n_best  = r_idx;
                        n_work  = cur;
                        n_state = S_MATCHED;
                    end else if (last_scan) begin
                        n_state = S_MATCHED;
                    end
                end else begin
                    if (cur.retrying && (!r_found || cur.deadline < r_work.deadline)) begin
                        n_found = 1'b1;
                        n_best  = r_idx;
                        n_work  = cur;
                    end
                    if (last_scan) begin
                        n_state = S_TICK_UPD;
                    end
                end
            end
            S_MATCHED: begin
                n_state = S_IDLE;
                n_dst   = r_best;
                if (r_found && (r_type == TYPE_RST || r_kind == KIND_RESPONSE)) begin
                    n_valid = 1'b1;
                    n_act   = ACT_COMPLETE;
                    n_stat  = (r_type == TYPE_RST) ? ST_CANCELLED : ST_OK;
                    n_eh    = r_work.handle;
                    n_ih    = r_handle;
                    n_dp    = r_peer;
                    n_state = S_MOVE;
                end else if (r_found && r_work.kind == KIND_REQUEST) begin
                    wr_en   = 1'b1;
                    wr_idx  = r_best;
                    wr_data = r_work;
                    wr_data.retrying = 1'b0;
                end else if (r_found && r_work.kind == KIND_RESPONSE) begin
                    n_state = S_MOVE;
                end else if (r_type == TYPE_CON) begin
                    n_valid = 1'b1;
                    n_act   = ACT_SEND_RST;
                    n_ih    = r_handle;
                    n_dp    = r_peer;
                    n_rid   = r_id;
                end
            end
            S_TICK_UPD: begin
                n_state = S_IDLE;
                if (r_found && r_now >= r_work.deadline) begin
                    n_work.timeout  = {r_work.timeout[30:0], 1'b0};
                    n_work.deadline = r_work.deadline + {r_work.timeout[30:0], 1'b0};
                    n_state = S_TICK_OUT;
                end
            end
            S_TICK_OUT: begin
                n_valid = 1'b1;
                n_eh    = r_work.handle;
                n_dp    = r_work.peer;
                n_dst   = r_best;
                if (r_work.retry_count >= r_max_retries) begin
                    n_act   = ACT_COMPLETE;
                    n_stat  = ST_TIMED_OUT;
                    n_state = S_MOVE;
                end else begin
                    n_act   = ACT_RESEND;
                    n_state = S_IDLE;
                    wr_en   = 1'b1;
                    wr_idx  = r_best;
                    wr_data = r_work;
                    wr_data.retry_count = r_work.retry_count + 3'd1;
                end
            end
            S_MOVE: begin
                // Removal: the last entry fills the freed slot.
                n_state = S_IDLE;
                n_count = r_count - CW'(1);
                wr_en   = 1'b1;
                wr_idx  = r_dst;
                wr_data = r_table[n_count[IW-1:0]];
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
        end
        r_idx   <= n_idx;
        r_best  <= n_best;
        r_found <= n_found;
        r_dst   <= n_dst;
        r_work  <= n_work;
        r_act   <= n_act;
        r_stat  <= n_stat;
        r_eh    <= n_eh;
        r_ih    <= n_ih;
        r_rid   <= n_rid;
        r_dp    <= n_dp;
        if (wr_en) begin
            r_table[wr_idx] <= wr_data;
        end
        if (accept) begin
            r_op     <= i_opcode;
            r_type   <= i_msg_type;
            r_kind   <= kind_of(i_msg_code);
            r_now    <= i_now_ms;
            r_peer   <= i_peer_key;
            r_id     <= i_message_id;
            r_handle <= i_msg_handle;
            r_rnd    <= i_random_word;
            r_tlen   <= in_tlen;
            r_tok    <= in_tok;
        end
    end

    assign busy              = (r_state != S_IDLE);
    assign o_valid           = r_valid;
    assign o_action          = r_act;
    assign o_status          = r_stat;
    assign o_entry_handle    = r_eh;
    assign o_incoming_handle = r_ih;
    assign o_dest_peer       = r_dp;
    assign o_reset_id        = r_rid;

endmodule

// ===== hw/rtl/cmrt_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmrt_checker: port-level checks of the reliability tracker.
// Watches the command handshake and result strobe.
// ----------------------------------------------------------------------------
module cmrt_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic [1:0] i_opcode,
    input logic       o_valid,
    input logic [2:0] o_action,
    input logic [1:0] o_status
);
    import cmrt_pkg::*;

    // A result never follows reset directly.
    a_no_result_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid) else $error("result after reset");

    // Idle after reset.
    a_idle_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !busy) else $error("busy after reset");

    // A non-complete result carries status ok.
    a_status_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_action != ACT_COMPLETE) |-> o_status == ST_OK)
        else $error("status on non-complete result");

    // An unknown opcode yields nothing and stays idle.
    a_unknown_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_opcode == OP_UNUSED) |=> (!busy && !o_valid))
        else $error("unknown opcode acted on");

    // A result only follows a transfer or work in progress.
    a_valid_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy || start)) else $error("result without cause");

endmodule

bind coap_message_reliability_tracker cmrt_checker u_cmrt_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .i_opcode(i_opcode),
    .o_valid (o_valid),
    .o_action(o_action),
    .o_status(o_status)
);
